// File: rtl/core/prq_pkg.sv
// Package for the packet ring queue: sizes, codes and controller/datapath interface types.
`default_nettype none

package prq_pkg;

    localparam int QUEUE_SLOTS = 16;
    localparam int SLOT_BYTES  = 64;

    localparam int SLOT_W     = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
    localparam int LEN_W      = $clog2(SLOT_BYTES + 1);
    localparam int COUNT_W    = $clog2(QUEUE_SLOTS + 1);
    localparam int MEM_DEPTH  = QUEUE_SLOTS * SLOT_BYTES;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);
    localparam int MAX_TAKE_W = 7;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA     = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_DISCARD  = 3'd3,
        ST_OVERLONG = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic accept_push;
        logic accept_pop;
        logic rd_issue;
        logic emit_byte;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic q_empty;
        logic pop_len_zero;
        logic byte_final;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/packet_ring_queue.sv
// Top level of the packet ring queue: controller and datapath joined by command and status.
// Usage:
//   The queue holds up to 16 whole packets of up to 64 bytes each in a ring of slots.
//   Input beats carry i_func, i_byte_in, i_byte_last and i_max_take on a valid/ready
//   channel. A push beat (i_func = 0) appends one byte to the packet filling the tail
//   slot; a byte with i_byte_last set commits that packet. A pop beat (i_func = 1)
//   removes the head packet and streams up to i_max_take of its bytes (capped at 64).
//   Every input beat gives at least one output beat; o_run_last marks the final one.
//   Status codes report full queue, empty queue, a zero-length take that discards the
//   packet, and bytes dropped past the slot size. o_packets_held is the packet count
//   after the beat's input took effect.
// Timing:
//   A push, or a pop that yields a single status beat, has its result
//   registered and visible the next cycle, and a new input beat is taken every cycle
//   while the output side keeps up. A pop that streams bytes reads each byte in S_READ
//   and outputs it in S_WAIT, as the byte store has one registered read port. No input
//   beat is taken while a pop is streaming.
// Reset and stall:
//   Synchronous active-low reset empties the queue and clears the output valid flag; the
//   byte store and length table hold no reset value and are only read once written.
//   When i_out_ready is low the output beat holds and the block stops taking input.
`default_nettype none

module packet_ring_queue (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_func,
    input  wire logic [prq_pkg::BYTE_W-1:0]         i_byte_in,
    input  wire logic                              i_byte_last,
    input  wire logic [prq_pkg::MAX_TAKE_W-1:0]     i_max_take,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [prq_pkg::STATUS_W-1:0]           o_status,
    output logic [prq_pkg::BYTE_W-1:0]             o_data_byte,
    output logic                                   o_run_last,
    output logic [prq_pkg::COUNT_W-1:0]            o_packets_held
);

    // Command and status between the state machine and the datapath.
    prq_pkg::t_cmd  cmd;
    prq_pkg::t_stat stat;

    prq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_ready (o_in_ready)
    );

    prq_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_byte_in      (i_byte_in),
        .i_byte_last    (i_byte_last),
        .i_max_take     (i_max_take),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_data_byte    (o_data_byte),
        .o_run_last     (o_run_last),
        .o_packets_held (o_packets_held)
    );

endmodule

`default_nettype wire

// File: rtl/core/prq_ctrl.sv
// Controller state machine of the packet ring queue: input handshake and pop streaming.
`default_nettype none

module prq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_func,
    input  wire prq_pkg::t_stat i_stat,
    output prq_pkg::t_cmd      o_cmd,
    output logic               o_in_ready
);

    prq_pkg::t_state r_state;
    prq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            prq_pkg::S_IDLE: begin
                if (i_in_valid && i_stat.out_free && (i_func == prq_pkg::FUNC_POP)
                        && !i_stat.q_empty && !i_stat.pop_len_zero) begin
                    n_state = prq_pkg::S_READ;
                end
            end
            prq_pkg::S_READ: begin
                n_state = prq_pkg::S_WAIT;
            end
            prq_pkg::S_WAIT: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.byte_final ? prq_pkg::S_IDLE : prq_pkg::S_READ;
                end
            end
            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            prq_pkg::S_IDLE: begin
                o_in_ready = i_stat.out_free;
                if (i_in_valid && i_stat.out_free) begin
                    if (i_func == prq_pkg::FUNC_POP) begin
                        o_cmd.accept_pop = 1'b1;
                    end else begin
                        o_cmd.accept_push = 1'b1;
                    end
                end
            end
            prq_pkg::S_READ: begin
                o_cmd.rd_issue = 1'b1;
            end
            prq_pkg::S_WAIT: begin
                o_cmd.emit_byte = i_stat.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/prq_dp.sv
// Datapath of the packet ring queue: byte store, length table, pointers and output register.
`default_nettype none

module prq_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire prq_pkg::t_cmd                i_cmd,
    output prq_pkg::t_stat                    o_stat,
    input  wire logic [prq_pkg::BYTE_W-1:0]     i_byte_in,
    input  wire logic                         i_byte_last,
    input  wire logic [prq_pkg::MAX_TAKE_W-1:0] i_max_take,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [prq_pkg::STATUS_W-1:0]      o_status,
    output logic [prq_pkg::BYTE_W-1:0]        o_data_byte,
    output logic                              o_run_last,
    output logic [prq_pkg::COUNT_W-1:0]       o_packets_held
);

    localparam int SLOT_W  = prq_pkg::SLOT_W;
    localparam int LEN_W   = prq_pkg::LEN_W;
    localparam int COUNT_W = prq_pkg::COUNT_W;
    localparam int ADDR_W  = prq_pkg::ADDR_W;
    localparam int TAKE_W  = prq_pkg::MAX_TAKE_W;
    localparam int BYTE_W  = prq_pkg::BYTE_W;

    // Storage without reset: only entries written earlier are ever read.
    logic [BYTE_W-1:0] r_mem     [prq_pkg::MEM_DEPTH];
    logic [LEN_W-1:0]  r_lengths [prq_pkg::QUEUE_SLOTS];
    logic [BYTE_W-1:0] r_rdata;

    logic [SLOT_W-1:0]  r_head, n_head;
    logic [SLOT_W-1:0]  r_tail, n_tail;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0]   r_fill, n_fill;

    logic [SLOT_W-1:0] r_pop_slot, n_pop_slot;
    logic [LEN_W-1:0]  r_pop_len, n_pop_len;
    logic [LEN_W-1:0]  r_pop_idx, n_pop_idx;

    logic               r_out_valid;
    prq_pkg::t_status   r_out_status, n_out_status;
    logic [BYTE_W-1:0]  r_out_data, n_out_data;
    logic               r_out_last, n_out_last;
    logic [COUNT_W-1:0] r_out_held;
    logic               out_load;

    logic              mem_we;
    logic              len_we;
    logic [LEN_W-1:0]  commit_len;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [TAKE_W-1:0] take_clamped;
    logic [LEN_W-1:0]  take_len;
    logic [LEN_W-1:0]  head_len;
    logic [LEN_W-1:0]  pop_len;
    logic              q_full;
    logic              byte_final;

    assign q_full       = (r_count >= COUNT_W'(prq_pkg::QUEUE_SLOTS));
    assign take_clamped = (i_max_take > TAKE_W'(prq_pkg::SLOT_BYTES))
                        ? TAKE_W'(prq_pkg::SLOT_BYTES) : i_max_take;
    assign take_len     = LEN_W'(take_clamped);
    assign head_len     = r_lengths[r_head];
    assign pop_len      = (head_len > take_len) ? take_len : head_len;
    assign byte_final   = ((r_pop_idx + LEN_W'(1)) == r_pop_len);

    assign wr_addr = ADDR_W'(r_tail) * ADDR_W'(prq_pkg::SLOT_BYTES) + ADDR_W'(r_fill);
    assign rd_addr = ADDR_W'(r_pop_slot) * ADDR_W'(prq_pkg::SLOT_BYTES) + ADDR_W'(r_pop_idx);

    assign o_stat.out_free     = !r_out_valid || i_out_ready;
    assign o_stat.q_empty      = (r_count == '0);
    assign o_stat.pop_len_zero = (pop_len == '0);
    assign o_stat.byte_final   = byte_final;

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_fill       = r_fill;
        n_pop_slot   = r_pop_slot;
        n_pop_len    = r_pop_len;
        n_pop_idx    = r_pop_idx;
        n_out_status = prq_pkg::ST_DATA;
        n_out_data   = '0;
        n_out_last   = 1'b1;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        len_we       = 1'b0;
        commit_len   = r_fill;

        if (i_cmd.accept_push) begin
            out_load = 1'b1;
            if (q_full) begin
                n_out_status = prq_pkg::ST_FULL;
            end else begin
                if (r_fill >= LEN_W'(prq_pkg::SLOT_BYTES)) begin
                    // Slot already full: the byte is dropped, the packet may still end.
                    n_out_status = prq_pkg::ST_OVERLONG;
                    commit_len   = r_fill;
                end else begin
                    mem_we     = 1'b1;
                    commit_len = r_fill + LEN_W'(1);
                    n_out_data = i_byte_in;
                end
                if (i_byte_last) begin
                    len_we  = 1'b1;
                    n_tail  = (r_tail == SLOT_W'(prq_pkg::QUEUE_SLOTS - 1))
                            ? '0 : r_tail + SLOT_W'(1);
                    n_count = r_count + COUNT_W'(1);
                    n_fill  = '0;
                end else begin
                    n_fill = commit_len;
                end
            end
        end

        if (i_cmd.accept_pop) begin
            if (r_count == '0) begin
                out_load     = 1'b1;
                n_out_status = prq_pkg::ST_EMPTY;
            end else begin
                n_head  = (r_head == SLOT_W'(prq_pkg::QUEUE_SLOTS - 1))
                        ? '0 : r_head + SLOT_W'(1);
                n_count = r_count - COUNT_W'(1);
                if (pop_len == '0) begin
                    out_load     = 1'b1;
                    n_out_status = prq_pkg::ST_DISCARD;
                end else begin
                    n_pop_slot = r_head;
                    n_pop_len  = pop_len;
                    n_pop_idx  = '0;
                end
            end
        end

        if (i_cmd.emit_byte) begin
            out_load   = 1'b1;
            n_out_data = r_rdata;
            n_out_last = byte_final;
            n_pop_idx  = r_pop_idx + LEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_byte_in;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_lengths[r_tail] <= commit_len;
        end
        r_pop_slot <= n_pop_slot;
        r_pop_len  <= n_pop_len;
        r_pop_idx  <= n_pop_idx;
        if (out_load) begin
            r_out_status <= n_out_status;
            r_out_data   <= n_out_data;
            r_out_last   <= n_out_last;
            r_out_held   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_fill  <= n_fill;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_data_byte    = r_out_data;
    assign o_run_last     = r_out_last;
    assign o_packets_held = r_out_held;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(prq_pkg::QUEUE_SLOTS))
        else $error("packet count above queue size");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(prq_pkg::SLOT_BYTES))
        else $error("fill length above slot size");

    a_ring_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == COUNT_W'(prq_pkg::QUEUE_SLOTS)) |-> (r_head == r_tail))
        else $error("head and tail disagree with packet count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_out_data) && $stable(r_out_status))
        else $error("output beat overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/packet_ring_queue_tb.sv
// Self-checking testbench for the packet ring queue: directed, full, overlong, stall, random.
`timescale 1ns / 100ps

module packet_ring_queue_tb;

    // Clock period in ns and the timeout, in cycles. The timeout covers the worst case
    // where every pop streams a full slot while the receiver stalls, with margin.
    localparam int CLK_PERIOD   = 4;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_BEATS = 120;
    localparam int REPORT_CAP   = 200;
    localparam int TAIL_CYCLES  = 8;

    localparam int BYTE_W      = prq_pkg::BYTE_W;
    localparam int MAX_TAKE_W  = prq_pkg::MAX_TAKE_W;
    localparam int STATUS_W    = prq_pkg::STATUS_W;
    localparam int COUNT_W     = prq_pkg::COUNT_W;
    localparam int QUEUE_SLOTS = prq_pkg::QUEUE_SLOTS;
    localparam int SLOT_BYTES  = prq_pkg::SLOT_BYTES;

    // One output beat as the checker expects it.
    typedef struct packed {
        prq_pkg::t_status     status;
        logic [BYTE_W-1:0]    data;
        logic                 last;
        logic [COUNT_W-1:0]   held;
    } t_queue_result;

    // Ways the receiver paces its ready signal.
    typedef enum int {
        RX_STREAM,
        RX_COIN,
        RX_PERIODIC,
        RX_STARVED
    } t_rx_mode;

    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_in_valid   = 1'b0;
    logic                   i_func       = prq_pkg::FUNC_PUSH;
    logic [BYTE_W-1:0]      i_byte_in    = '0;
    logic                   i_byte_last  = 1'b0;
    logic [MAX_TAKE_W-1:0]  i_max_take   = '0;
    logic                   i_out_ready  = 1'b0;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [BYTE_W-1:0]      o_data_byte;
    logic                   o_run_last;
    logic [COUNT_W-1:0]     o_packets_held;

    packet_ring_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_byte_in      (i_byte_in),
        .i_byte_last    (i_byte_last),
        .i_max_take     (i_max_take),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_data_byte    (o_data_byte),
        .o_run_last     (o_run_last),
        .o_packets_held (o_packets_held)
    );

    // Shadow copy of the queue, updated once per accepted input beat.
    logic [BYTE_W-1:0] shadow_bytes   [prq_pkg::MEM_DEPTH];
    int                shadow_lengths [QUEUE_SLOTS];
    int                shadow_head  = 0;
    int                shadow_tail  = 0;
    int                shadow_count = 0;
    int                shadow_fill  = 0;

    // Output beats predicted but not yet seen, oldest first.
    t_queue_result pending_results [$];

    int fail_count   = 0;
    int beats_sent   = 0;
    int burst_left   = 0;
    int cycle_count  = 0;

    // The test raises a ticket to ask for one long receiver hold-off; the receiver
    // process serves it and counts the stalled cycles itself.
    int hold_off_tickets = 0;
    int hold_off_served  = 0;

    initial begin : clock_gen
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Builds one result; every result reports the packet count after the beat.
    function automatic t_queue_result make_result(prq_pkg::t_status st,
                                                  logic [BYTE_W-1:0] data, logic last);
        make_result = '{status: st, data: data, last: last,
                        held: COUNT_W'(shadow_count)};
    endfunction

    function automatic void commit_shadow_packet();
        shadow_lengths[shadow_tail] = shadow_fill;
        shadow_tail  = (shadow_tail + 1) % QUEUE_SLOTS;
        shadow_count = shadow_count + 1;
        shadow_fill  = 0;
    endfunction

    // Applies one accepted input beat to the shadow queue and queues the output
    // beats it must produce.
    function automatic void predict_queue_results(logic func, logic [BYTE_W-1:0] data,
                                                  logic last, logic [MAX_TAKE_W-1:0] take);
        int slot;
        int len;
        int cap;
        if (func == prq_pkg::FUNC_PUSH) begin
            if (shadow_count >= QUEUE_SLOTS) begin
                // Full queue: the byte is lost and the filling packet stays as it was.
                pending_results.push_back(make_result(prq_pkg::ST_FULL, '0, 1'b1));
            end else if (shadow_fill >= SLOT_BYTES) begin
                // Slot already full: drop the byte, but a last flag still commits.
                shadow_fill = SLOT_BYTES;
                if (last)
                    commit_shadow_packet();
                pending_results.push_back(make_result(prq_pkg::ST_OVERLONG, '0, 1'b1));
            end else begin
                shadow_bytes[shadow_tail * SLOT_BYTES + shadow_fill] = data;
                shadow_fill = shadow_fill + 1;
                if (last)
                    commit_shadow_packet();
                pending_results.push_back(make_result(prq_pkg::ST_DATA, data, 1'b1));
            end
        end else if (shadow_count == 0) begin
            pending_results.push_back(make_result(prq_pkg::ST_EMPTY, '0, 1'b1));
        end else begin
            slot = shadow_head;
            len  = shadow_lengths[slot];
            cap  = (int'(take) > SLOT_BYTES) ? SLOT_BYTES : int'(take);
            if (len > cap)
                len = cap;
            shadow_head  = (shadow_head + 1) % QUEUE_SLOTS;
            shadow_count = shadow_count - 1;
            if (len == 0) begin
                pending_results.push_back(make_result(prq_pkg::ST_DISCARD, '0, 1'b1));
            end else begin
                for (int i = 0; i < len; i++)
                    pending_results.push_back(make_result(prq_pkg::ST_DATA,
                        shadow_bytes[slot * SLOT_BYTES + i], (i + 1 == len)));
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    // Counts a failure; detailed lines stop after a cap so a broken build cannot
    // flood the log.
    function automatic void note_mismatch(string field, int want, int got);
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_CAP)
            $display("%0t ns: %s mismatch: expected %0d, actual %0d",
                     $time, field, want, got);
    endfunction

    // Every output beat taken by the receiver is compared with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_queue_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= REPORT_CAP)
                    $display({"%0t ns: unexpected output beat: expected none, ",
                              "actual status %0d data %0d"},
                             $time, o_status, o_data_byte);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    note_mismatch("status", want.status, o_status);
                if (o_data_byte !== want.data)
                    note_mismatch("data_byte", want.data, o_data_byte);
                if (o_run_last !== want.last)
                    note_mismatch("run_last", want.last, o_run_last);
                if (o_packets_held !== want.held)
                    note_mismatch("packets_held", want.held, o_packets_held);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver pacing
    // ------------------------------------------------------------------

    // The receiver switches between pacing modes at random intervals, so that
    // stalls land on every phase of a pop stream, with clean streaming stretches too.
    initial begin : drive_out_ready
        t_rx_mode mode;
        int mode_left;
        int period;
        int phase;
        int hold_left;
        mode      = RX_STREAM;
        mode_left = 0;
        period    = 2;
        phase     = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left = hold_left - 1;
            end else if (hold_off_tickets != hold_off_served) begin
                // Long hold-off: the output stalls, so the block stops taking input.
                hold_off_served = hold_off_served + 1;
                hold_left = $urandom_range(400, 200) - 1;
                i_out_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(3, 0));
                    mode_left = $urandom_range(200, 20);
                    period    = $urandom_range(5, 2);
                end
                mode_left = mode_left - 1;
                phase     = phase + 1;
                case (mode)
                    RX_STREAM:   i_out_ready <= 1'b1;
                    RX_COIN:     i_out_ready <= 1'($urandom_range(1, 0));
                    RX_PERIODIC: i_out_ready <= ((phase % period) != 0);
                    default:     i_out_ready <= ($urandom_range(3, 0) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Timeout
    // ------------------------------------------------------------------

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count = cycle_count + 1;
        end
        $display("** packet_ring_queue: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offers one input beat and returns at the edge where it is accepted. Valid is
    // left high so that back-to-back beats keep it up; this task drops it only at
    // the start of a gap between bursts.
    task automatic send_beat(logic func, logic [BYTE_W-1:0] data, logic last,
                             logic [MAX_TAKE_W-1:0] take);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(4, 0) == 0) ? 0 : $urandom_range(6, 1);
            burst_left = $urandom_range(16, 1);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_in_valid  <= 1'b1;
        i_func      <= func;
        i_byte_in   <= data;
        i_byte_last <= last;
        i_max_take  <= take;
        do @(posedge i_clk); while (!o_in_ready);
        predict_queue_results(func, data, last, take);
        beats_sent = beats_sent + 1;
    endtask

    // Push beats carry a random, ignored max_take and pops carry random, ignored
    // byte fields, so every input bit toggles.
    task automatic push_byte(logic [BYTE_W-1:0] data, logic last);
        send_beat(prq_pkg::FUNC_PUSH, data, last, MAX_TAKE_W'($urandom));
    endtask

    task automatic pop_packet(logic [MAX_TAKE_W-1:0] take);
        send_beat(prq_pkg::FUNC_POP, BYTE_W'($urandom), 1'($urandom), take);
    endtask

    // Pushes len random bytes; the final one carries the last flag when asked.
    task automatic push_bytes(int len, bit close);
        for (int i = 0; i < len; i++)
            push_byte(BYTE_W'($urandom), close && (i + 1 == len));
    endtask

    // Drops valid and waits at least one edge, then until every result is in.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Packet lengths lean short so that the run stays quick, with some full slots
    // and a few that spill past the slot size.
    function automatic int pick_packet_len();
        int p;
        p = $urandom_range(99, 0);
        if (p < 65)
            pick_packet_len = $urandom_range(6, 1);
        else if (p < 88)
            pick_packet_len = $urandom_range(40, 7);
        else if (p < 95)
            pick_packet_len = $urandom_range(SLOT_BYTES, 41);
        else
            pick_packet_len = $urandom_range(SLOT_BYTES + 4, SLOT_BYTES);
    endfunction

    // Take sizes cover zero, the slot size, values above it, and small truncations.
    function automatic logic [MAX_TAKE_W-1:0] pick_take();
        int p;
        p = $urandom_range(99, 0);
        if (p < 12)
            pick_take = '0;
        else if (p < 24)
            pick_take = MAX_TAKE_W'($urandom_range(127, SLOT_BYTES + 1));
        else if (p < 34)
            pick_take = MAX_TAKE_W'(SLOT_BYTES);
        else
            pick_take = MAX_TAKE_W'($urandom_range(24, 1));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short directed pass: empty pops, byte extremes, discard, truncation and
    // takes above the slot size.
    task automatic test_directed();
        pop_packet('0);
        pop_packet(7'h7F);
        push_byte(8'h00, 1'b1);
        pop_packet(7'd1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);
        pop_packet(7'h7F);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);
        pop_packet('0);
        push_bytes(4, 1'b1);
        pop_packet(7'd2);
        push_byte(8'h3C, 1'b1);
        pop_packet(MAX_TAKE_W'(SLOT_BYTES));
        pop_packet(7'd5);
        wait_for_drain();
    endtask

    // Bytes past the slot size are dropped, whether or not they carry the last flag;
    // the packet then commits at exactly the slot size.
    task automatic test_overlong();
        push_bytes(SLOT_BYTES + 2, 1'b0);
        push_byte(8'hC3, 1'b1);
        push_bytes(SLOT_BYTES, 1'b1);
        push_bytes(SLOT_BYTES + 1, 1'b1);
        pop_packet(7'h7F);
        pop_packet(MAX_TAKE_W'(SLOT_BYTES));
        pop_packet(MAX_TAKE_W'(SLOT_BYTES - 1));
        wait_for_drain();
    endtask

    // Fills every slot, shows that pushes on a full queue are dropped even with the
    // last flag set, then empties the ring across the wrap.
    task automatic test_full_queue();
        for (int i = 0; i < QUEUE_SLOTS - 1; i++)
            push_bytes($urandom_range(3, 1), 1'b1);
        // The last slot fills partly with open bytes, then its closing byte fills the queue.
        push_bytes(2, 1'b0);
        push_byte(8'hE7, 1'b1);
        push_byte(8'h11, 1'b0);
        push_byte(8'h22, 1'b1);
        pop_packet(pick_take());
        push_byte(8'h33, 1'b1);
        push_byte(8'h44, 1'b1);
        while (shadow_count > 0)
            pop_packet(pick_take());
        pop_packet(pick_take());
        wait_for_drain();
    endtask

    // The receiver holds off for a long stretch while the sender keeps offering
    // beats; once it resumes, everything must come out in order.
    task automatic test_backpressure();
        hold_off_tickets = hold_off_tickets + 1;
        for (int i = 0; i < 8; i++) begin
            push_bytes($urandom_range(5, 1), 1'b1);
            if ($urandom_range(1, 0))
                pop_packet(pick_take());
        end
        wait_for_drain();
    endtask

    // Mostly well-formed packet traffic with random content; the rest is noise:
    // lone bytes, stray pops and packets left open to continue later.
    task automatic test_random();
        int start;
        int p;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            p = $urandom_range(99, 0);
            if (shadow_count == QUEUE_SLOTS && p < 85)
                pop_packet(pick_take());
            else if (p < 55)
                push_bytes(pick_packet_len(), 1'b1);
            else if (p < 88)
                pop_packet(pick_take());
            else if (p < 93)
                push_byte(BYTE_W'($urandom), 1'($urandom));
            else if (p < 97)
                push_bytes($urandom_range(5, 1), 1'b0);
            else
                pop_packet(MAX_TAKE_W'($urandom));
            // Now and then the sender stops until the queue has caught up.
            if ($urandom_range(49, 0) == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    initial begin : run_tests
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_overlong();
        test_full_queue();
        test_backpressure();
        test_random();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("** packet_ring_queue: PASSED **");
        end else begin
            $display("** packet_ring_queue: FAILED **");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/prq_pkg.sv
rtl/core/prq_ctrl.sv
rtl/core/prq_dp.sv
rtl/core/packet_ring_queue.sv
tb/packet_ring_queue_tb.sv
